FILE: src/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg
// Shared constants and types for the stair-ways counter.
// ----------------------------------------------------------------------------
package swk_pkg;

  // parameter defaults
  localparam int K_MAX_DEF       = 16;
  localparam int N_MAX_DEF       = 1023;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int STEP_W = 10;
  localparam int JUMP_W = 5;

  localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIN
  } state_t;

endpackage

FILE: src/swk_ram.sv
// ----------------------------------------------------------------------------
// swk_ram
// Window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swk_ram #(
  parameter int DEPTH = 17,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/swk_ctrl.sv
// ----------------------------------------------------------------------------
// swk_ctrl
// Sequencer and recurrence datapath; drives the window store.
// ----------------------------------------------------------------------------
module swk_ctrl #(
  parameter int K_MAX       = 16,
  parameter int N_MAX       = 1023,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [swk_pkg::STEP_W-1:0]     step_count,
  input  logic [swk_pkg::JUMP_W-1:0]     max_jump,
  output logic                           busy,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [VALUE_WIDTH-1:0]         res_ways,
  output logic                           res_ovf,
  output logic                           ram_we,
  output logic [$clog2(K_MAX+1)-1:0]     ram_waddr,
  output logic [VALUE_WIDTH-1:0]         ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(K_MAX+1)-1:0]     ram_raddr,
  input  logic [VALUE_WIDTH-1:0]         ram_rdata
);
  import swk_pkg::*;

  localparam int DEPTH = K_MAX + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(N_MAX + 1);
  localparam int KW    = $clog2(K_MAX + 1);
  localparam int CW    = (NW > KW) ? NW : KW;

  state_t                 state_r, state_nxt;
  logic [NW-1:0]          i_r, i_nxt;
  logic [NW-1:0]          n_r, n_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [VALUE_WIDTH-1:0] cur_r, cur_nxt;
  logic                   wrap_r, wrap_nxt;
  logic [PW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]          rd_ptr_r, rd_ptr_nxt;

  logic [NW-1:0]          n_clamp;
  logic [KW-1:0]          k_clamp;
  logic [VALUE_WIDTH-1:0] cur_dbl;
  logic [VALUE_WIDTH-1:0] next_val;

  // input clamping: zero jump acts as one, oversized values saturate
  always_comb begin
    if (32'(step_count) > 32'(N_MAX)) begin
      n_clamp = NW'(N_MAX);
    end else begin
      n_clamp = NW'(step_count);
    end
    if (max_jump == '0) begin
      k_clamp = KW'(1);
    end else if (32'(max_jump) > 32'(K_MAX)) begin
      k_clamp = KW'(K_MAX);
    end else begin
      k_clamp = KW'(max_jump);
    end
  end

  assign cur_dbl = {cur_r[VALUE_WIDTH-2:0], 1'b0};

  always_comb begin
    if (i_r == NW'(1)) begin
      next_val = VALUE_WIDTH'(1);
    end else if (CW'(i_r) <= CW'(k_r)) begin
      next_val = cur_dbl;
    end else begin
      next_val = cur_dbl - ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      i_r      <= '0;
      wrap_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      wrap_r   <= wrap_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    wrap_nxt   = wrap_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    busy       = 1'b1;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_r;
    ram_wdata  = next_val;
    ram_re     = 1'b0;
    ram_raddr  = rd_ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          // seed window[0] = 1
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = VALUE_WIDTH'(1);
          i_nxt      = NW'(1);
          n_nxt      = n_clamp;
          k_nxt      = k_clamp;
          cur_nxt    = VALUE_WIDTH'(1);
          wrap_nxt   = 1'b0;
          wr_ptr_nxt = PW'(1);
          rd_ptr_nxt = '0;
          state_nxt  = (n_clamp == '0) ? ST_FIN : ST_STEP;
        end
      end
      ST_STEP: begin
        ram_we  = 1'b1;
        cur_nxt = next_val;
        if (next_val < cur_r) begin
          wrap_nxt = 1'b1;
        end
        wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
        // prefetch the tap for the next step: entry (i+1)-k-1
        if (CW'(i_r) >= CW'(k_r)) begin
          ram_re     = 1'b1;
          rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
        end
        if (i_r == n_r) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt = i_r + NW'(1);
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_ways = cur_r;
  assign res_ovf  = wrap_r;

endmodule

FILE: src/stair_ways_k_jumps.sv
// Sequence: the accepting cycle writes the seed, each ST_STEP state computes one
//   recurrence step, then ST_FIN hands the result to the output register.
// Throughput: a new transaction is accepted only after the last one leaves ST_FIN;
//   the single window RAM port pair carries one recurrence step per cycle.
// Reset: synchronous active-low rst_n idles the sequencer, drops out_valid and
//   sets max_jump to 2. Window contents need no clearing.
// ----------------------------------------------------------------------------
// stair_ways_k_jumps
// Counts jump sequences up a staircase with jumps of 1..k steps, mod 2^W.
// ----------------------------------------------------------------------------
module stair_ways_k_jumps #(
  parameter int K_MAX       = swk_pkg::K_MAX_DEF,
  parameter int N_MAX       = swk_pkg::N_MAX_DEF,
  parameter int VALUE_WIDTH = swk_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [swk_pkg::JUMP_W-1:0]     cfg_wr_data,
  // input transaction
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [swk_pkg::STEP_W-1:0]     in_step_count,
  // result transaction
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [VALUE_WIDTH-1:0]         out_ways,
  output logic                           out_overflowed
);
  import swk_pkg::*;

  localparam int PW = $clog2(K_MAX + 1);

  // max_jump register; clamping to 1..K_MAX happens at transaction start
  logic [JUMP_W-1:0] max_jump_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jump_r <= JUMP_RESET;
    end else if (cfg_wr_en) begin
      max_jump_r <= cfg_wr_data;
    end
  end

  // sequencer <-> window RAM
  logic                   ram_we, ram_re;
  logic [PW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   busy;
  logic                   res_valid, res_ready;
  logic [VALUE_WIDTH-1:0] res_ways;
  logic                   res_ovf;
  logic                   start;

  // one transaction in flight; a result in the output register does not block acceptance, one still in ST_FIN does
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  swk_ctrl #(
    .K_MAX       (K_MAX),
    .N_MAX       (N_MAX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .step_count (in_step_count),
    .max_jump   (max_jump_r),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_ways   (res_ways),
    .res_ovf    (res_ovf),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Window of the last K_MAX+1 counts. Each tap is read in a later cycle than
  // its write, and never at the address being written, so no bypass.
  swk_ram #(
    .DEPTH (K_MAX + 1),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: holds the result while the consumer stalls.
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_ways_r;
  logic                   out_ovf_r;

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_ways_r <= res_ways;
      out_ovf_r  <= res_ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ways       = out_ways_r;
  assign out_overflowed = out_ovf_r;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stair-ways counter. Step counts go in through
// the input channel, each result is checked against an in-bench recount of
// the jump sequences at the jump limit in force, under random idling on both
// channels and several jump limit settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VW        = swk_pkg::VALUE_WIDTH_DEF;
  localparam int KMAX      = swk_pkg::K_MAX_DEF;
  localparam int SW        = swk_pkg::STEP_W;
  localparam int WIN_DEPTH = KMAX + 1;
  localparam int IDLE_PCT  = 34;

  typedef struct packed {
    logic [VW-1:0] ways;
    logic          overflowed;
  } climb_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [swk_pkg::JUMP_W-1:0]  cfg_wr_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [swk_pkg::STEP_W-1:0]  in_step_count;
  logic                        out_valid;
  logic                        out_stall;
  logic [VW-1:0]               out_ways;
  logic                        out_overflowed;

  // jump limit the block currently holds, as last written
  logic [swk_pkg::JUMP_W-1:0]  jump_limit;
  // results owed by the block, oldest first
  climb_result_t               ways_due[$];
  // when set, neither side idles
  bit                          calm;
  int                          errors;

  stair_ways_k_jumps dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_step_count  (in_step_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ways       (out_ways),
    .out_overflowed (out_overflowed)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Recount: ways(0)=1, ways(1)=1, doubling up to k, then the sliding sum
  // 2*ways(i-1) - ways(i-k-1). The true count never drops, so any drop means
  // the 32-bit value wrapped; the flag covers this step count only.
  // --------------------------------------------------------------------------
  function automatic climb_result_t count_ways(input logic [swk_pkg::STEP_W-1:0] n,
                                               input logic [swk_pkg::JUMP_W-1:0] jump);
    climb_result_t r;
    logic [VW-1:0] win [WIN_DEPTH];
    logic [VW-1:0] cur;
    logic [VW-1:0] nxt;
    int            k;
    int            i;
    k = int'(jump);
    if (k < 1) k = 1;          // zero jump limit behaves as 1
    if (k > KMAX) k = KMAX;    // oversize jump limit saturates
    win[0]       = 1;
    cur          = 1;
    r.overflowed = 1'b0;
    for (i = 1; i <= int'(n); i++) begin
      if (i == 1)
        nxt = 1;
      else if (i <= k)
        nxt = {cur[VW-2:0], 1'b0};
      else
        nxt = {cur[VW-2:0], 1'b0} - win[(i - k - 1) % WIN_DEPTH];
      if (nxt < cur) r.overflowed = 1'b1;
      win[i % WIN_DEPTH] = nxt;
      cur = nxt;
    end
    r.ways = cur;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, with random idle cycles ahead of it.
  // Data change only at the falling edge; acceptance is seen at the rising one.
  // in_valid stays high after acceptance until the next call or a drain.
  // --------------------------------------------------------------------------
  task automatic climb(input logic [swk_pkg::STEP_W-1:0] n);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_step_count <= n;
    do @(posedge clk); while (in_stall);
    ways_due.push_back(count_ways(n, jump_limit));
  endtask

  // Drop valid and hold off until every owed result is back, plus a margin.
  // Every step count yields a result, so an empty queue means the block is idle.
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ways_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write; callers drain first so the block is idle.
  task automatic set_jump(input logic [swk_pkg::JUMP_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    jump_limit = v;
  endtask

  // Mostly short staircases; long ones are rare since their run time grows with n.
  function automatic logic [swk_pkg::STEP_W-1:0] pick_steps();
    int r;
    r = $urandom_range(99);
    if (r < 70) return SW'($urandom_range(63, 0));
    if (r < 90) return SW'($urandom_range(255, 64));
    if (r < 97) return SW'($urandom_range(511, 256));
    return SW'($urandom_range(1023, 512));
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall, then field checks on each accepted transaction.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (calm)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    climb_result_t want;
    if (out_valid && !out_stall) begin
      if (ways_due.size() == 0) begin
        $error("unexpected result: ways=%0d overflowed=%0b", out_ways, out_overflowed);
        errors++;
      end else begin
        want = ways_due.pop_front();
        if (out_ways !== want.ways) begin
          $error("ways: expected %0d, got %0d", want.ways, out_ways);
          errors++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, out_overflowed);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset jump limit of 2: Fibonacci counts. ways(46) is the last that fits,
  // ways(47) wraps. Zero steps gives 1.
  task automatic test_default_jump();
    climb(0);
    climb(1);
    climb(2);
    climb(3);
    climb(46);
    climb(47);
    climb(1023);
    await_idle();
  endtask

  // Jump limit extremes: zero acts as 1, above 16 saturates, all-ones field.
  task automatic test_jump_limits();
    set_jump(0);
    climb(0);
    climb(2);
    climb(1023);
    await_idle();
    set_jump(1);
    climb(1);
    climb(512);
    await_idle();
    set_jump(5'(KMAX));
    climb(16);
    climb(17);
    climb(32);
    climb(33);
    climb(34);
    climb(682);
    await_idle();
    set_jump(17);
    climb(341);
    await_idle();
    set_jump(31);
    climb(1023);
    climb(40);
    await_idle();
  endtask

  // Random staircases over several jump limits, with occasional full drains.
  task automatic test_random_climbs();
    logic [swk_pkg::JUMP_W-1:0] limits [9];
    int p;
    int j;
    limits = '{5'd2, 5'd1, 5'd16, 5'd31, 5'd0, 5'd3,
               5'($urandom_range(31)), 5'($urandom_range(16, 1)), 5'd17};
    for (p = 0; p < 9; p++) begin
      set_jump(limits[p]);
      for (j = 0; j < 60; j++) begin
        climb(pick_steps());
        if ($urandom_range(39) == 0) await_idle();
      end
      await_idle();
    end
  endtask

  // Back-to-back transactions, no idling on either side.
  task automatic test_steady_stream();
    int j;
    set_jump(5'($urandom_range(16, 1)));
    calm = 1'b1;
    for (j = 0; j < 40; j++) climb(pick_steps());
    await_idle();
    calm = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_step_count = '0;
    out_stall     = 1'b0;
    calm          = 1'b0;
    errors        = 0;
    jump_limit    = swk_pkg::JUMP_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_default_jump();
    test_jump_limits();
    test_random_climbs();
    test_steady_stream();

    // watch for stray results
    await_idle();
    repeat (1100) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
src/swk_pkg.sv
src/swk_ram.sv
src/swk_ctrl.sv
src/stair_ways_k_jumps.sv
tb/sv/tb_top.sv
